FILE: hdl/usc_pkg.sv
package usc_pkg;

    localparam logic [20:0] USC_RECIP_3600 = 21'd1193046;
    localparam logic [16:0] USC_RECIP_24   = 17'd87381;
    localparam logic [6:0]  USC_RECIP_60   = 7'd68;
    localparam logic [5:0]  USC_RECIP_1461 = 6'd44;

    localparam logic [31:0] USC_SECS_PER_HOUR = 32'd3600;
    localparam logic [15:0] USC_DAYS_PER_CYCLE = 16'd1461;
    localparam logic [15:0] USC_DAYS_PER_YEAR = 16'd365;
    localparam logic [7:0]  USC_YEAR_BIAS = 8'd31;

    typedef struct packed {
        logic [15:0] days_ofs;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_split;

    typedef struct packed {
        logic signed [7:0] year_since_2000;
        logic [3:0]        month_of_year;
        logic [4:0]        day_of_month;
        logic [4:0]        hour_of_day;
        logic [5:0]        minute_of_hour;
        logic [5:0]        second_of_minute;
    } t_result;

    function automatic logic [8:0] usc_month_start(input logic [3:0] mon, input logic leap);
        logic [8:0] base;
        case (mon)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (mon >= 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

FILE: hdl/usc_if.sv
interface usc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] unix_seconds;

    modport source (output valid, output unix_seconds, input ready);
    modport sink (input valid, input unix_seconds, output ready);
endinterface

interface usc_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] year_since_2000;
    logic [3:0]        month_of_year;
    logic [4:0]        day_of_month;
    logic [4:0]        hour_of_day;
    logic [5:0]        minute_of_hour;
    logic [5:0]        second_of_minute;

    modport source (
        output valid, output year_since_2000, output month_of_year, output day_of_month,
        output hour_of_day, output minute_of_hour, output second_of_minute, input ready
    );
    modport sink (
        input valid, input year_since_2000, input month_of_year, input day_of_month,
        input hour_of_day, input minute_of_hour, input second_of_minute, output ready
    );
endinterface

FILE: hdl/usc_time_split.sv
module usc_time_split (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [31:0]           i_seconds,
    output logic                  o_valid,
    input  logic                  i_ready,
    output usc_pkg::t_split       o_split
);

    logic [3:0] r_vld;
    logic [3:0] ld;

    logic [31:0] r_s1_sec;
    logic [20:0] r_s1_q;
    logic [20:0] r_s2_hrs;
    logic [11:0] r_s2_rem;
    logic [20:0] r_s3_hrs;
    logic [11:0] r_s3_rem;
    logic [15:0] r_s3_dq;
    logic [5:0]  r_s3_mq;
    usc_pkg::t_split r_s4;

    logic [52:0] w_prod1;
    logic [31:0] w_sub2;
    logic [12:0] w_rem2;
    logic [20:0] n_s2_hrs;
    logic [11:0] n_s2_rem;
    logic [37:0] w_prod3d;
    logic [18:0] w_prod3m;
    logic [20:0] w_hsub;
    logic [11:0] w_msub;
    logic [5:0]  w_h6;
    logic [6:0]  w_s7;
    logic [15:0] w_days;
    usc_pkg::t_split n_s4;

    always_comb begin
        ld[3] = !r_vld[3] || i_ready;
        ld[2] = !r_vld[2] || ld[3];
        ld[1] = !r_vld[1] || ld[2];
        ld[0] = !r_vld[0] || ld[1];
    end

    assign o_ready = ld[0];
    assign o_valid = r_vld[3];
    assign o_split = r_s4;

    assign w_prod1 = {21'd0, i_seconds} * {32'd0, usc_pkg::USC_RECIP_3600};

    always_comb begin
        w_sub2 = r_s1_sec - ({11'd0, r_s1_q} * usc_pkg::USC_SECS_PER_HOUR);
        w_rem2 = w_sub2[12:0];
        if (w_rem2 >= usc_pkg::USC_SECS_PER_HOUR[12:0]) begin
            n_s2_hrs = r_s1_q + 21'd1;
            n_s2_rem = 12'(w_rem2 - usc_pkg::USC_SECS_PER_HOUR[12:0]);
        end else begin
            n_s2_hrs = r_s1_q;
            n_s2_rem = w_rem2[11:0];
        end
    end

    assign w_prod3d = {17'd0, r_s2_hrs} * {21'd0, usc_pkg::USC_RECIP_24};
    assign w_prod3m = {7'd0, r_s2_rem} * {12'd0, usc_pkg::USC_RECIP_60};

    always_comb begin
        w_hsub = r_s3_hrs - ({5'd0, r_s3_dq} * 21'd24);
        w_msub = r_s3_rem - ({6'd0, r_s3_mq} * 12'd60);
        w_h6 = w_hsub[5:0];
        w_s7 = w_msub[6:0];
        if (w_h6 >= 6'd24) begin
            w_days = r_s3_dq + 16'd1;
            n_s4.hour = 5'(w_h6 - 6'd24);
        end else begin
            w_days = r_s3_dq;
            n_s4.hour = w_h6[4:0];
        end
        if (w_s7 >= 7'd60) begin
            n_s4.minute = r_s3_mq + 6'd1;
            n_s4.second = 6'(w_s7 - 7'd60);
        end else begin
            n_s4.minute = r_s3_mq;
            n_s4.second = w_s7[5:0];
        end
        n_s4.days_ofs = w_days + usc_pkg::USC_DAYS_PER_YEAR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) r_vld[0] <= i_valid;
            if (ld[1]) r_vld[1] <= r_vld[0];
            if (ld[2]) r_vld[2] <= r_vld[1];
            if (ld[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_s1_sec <= i_seconds;
            r_s1_q <= w_prod1[52:32];
        end
        if (ld[1]) begin
            r_s2_hrs <= n_s2_hrs;
            r_s2_rem <= n_s2_rem;
        end
        if (ld[2]) begin
            r_s3_hrs <= r_s2_hrs;
            r_s3_rem <= r_s2_rem;
            r_s3_dq <= w_prod3d[36:21];
            r_s3_mq <= w_prod3m[17:12];
        end
        if (ld[3]) begin
            r_s4 <= n_s4;
        end
    end

endmodule

FILE: hdl/usc_date_calc.sv
module usc_date_calc (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  usc_pkg::t_split       i_split,
    output logic                  o_valid,
    input  logic                  i_ready,
    output usc_pkg::t_result      o_result
);

    logic [3:0] r_vld;
    logic [3:0] ld;

    usc_pkg::t_split r_s5_t;
    logic [5:0]  r_s5_c;
    usc_pkg::t_split r_s6_t;
    logic [5:0]  r_s6_c;
    logic [10:0] r_s6_rem;
    usc_pkg::t_split r_s7_t;
    logic [8:0]  r_s7_doy;
    logic        r_s7_leap;
    logic [7:0]  r_s7_year;
    usc_pkg::t_result r_s8;

    logic [21:0] w_prod5;
    logic [15:0] w_sub6;
    logic [11:0] w_rem6;
    logic [5:0]  n_s6_c;
    logic [10:0] n_s6_rem;
    logic [1:0]  w_yic;
    logic [10:0] w_doy;
    logic [3:0]  w_mon;
    logic [8:0]  w_dom;
    logic [8:0]  w_start;

    always_comb begin
        ld[3] = !r_vld[3] || i_ready;
        ld[2] = !r_vld[2] || ld[3];
        ld[1] = !r_vld[1] || ld[2];
        ld[0] = !r_vld[0] || ld[1];
    end

    assign o_ready = ld[0];
    assign o_valid = r_vld[3];
    assign o_result = r_s8;

    assign w_prod5 = {6'd0, i_split.days_ofs} * {16'd0, usc_pkg::USC_RECIP_1461};

    always_comb begin
        w_sub6 = r_s5_t.days_ofs - ({10'd0, r_s5_c} * usc_pkg::USC_DAYS_PER_CYCLE);
        w_rem6 = w_sub6[11:0];
        if (w_rem6 >= usc_pkg::USC_DAYS_PER_CYCLE[11:0]) begin
            n_s6_c = r_s5_c + 6'd1;
            n_s6_rem = 11'(w_rem6 - usc_pkg::USC_DAYS_PER_CYCLE[11:0]);
        end else begin
            n_s6_c = r_s5_c;
            n_s6_rem = w_rem6[10:0];
        end
    end

    always_comb begin
        if (r_s6_rem >= 11'd1095) begin
            w_yic = 2'd3;
            w_doy = r_s6_rem - 11'd1095;
        end else if (r_s6_rem >= 11'd730) begin
            w_yic = 2'd2;
            w_doy = r_s6_rem - 11'd730;
        end else if (r_s6_rem >= 11'd365) begin
            w_yic = 2'd1;
            w_doy = r_s6_rem - 11'd365;
        end else begin
            w_yic = 2'd0;
            w_doy = r_s6_rem;
        end
    end

    always_comb begin
        w_mon = 4'd0;
        w_dom = r_s7_doy;
        for (int m = 1; m < 12; m++) begin
            w_start = usc_pkg::usc_month_start(4'(m), r_s7_leap);
            if (r_s7_doy >= w_start) begin
                w_mon = 4'(m);
                w_dom = r_s7_doy - w_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) r_vld[0] <= i_valid;
            if (ld[1]) r_vld[1] <= r_vld[0];
            if (ld[2]) r_vld[2] <= r_vld[1];
            if (ld[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_s5_t <= i_split;
            r_s5_c <= w_prod5[21:16];
        end
        if (ld[1]) begin
            r_s6_t <= r_s5_t;
            r_s6_c <= n_s6_c;
            r_s6_rem <= n_s6_rem;
        end
        if (ld[2]) begin
            r_s7_t <= r_s6_t;
            r_s7_doy <= w_doy[8:0];
            r_s7_leap <= (w_yic == 2'd3);
            r_s7_year <= {r_s6_c, w_yic} - usc_pkg::USC_YEAR_BIAS;
        end
        if (ld[3]) begin
            r_s8.year_since_2000 <= $signed(r_s7_year);
            r_s8.month_of_year <= w_mon + 4'd1;
            r_s8.day_of_month <= 5'(w_dom + 9'd1);
            r_s8.hour_of_day <= r_s7_t.hour;
            r_s8.minute_of_hour <= r_s7_t.minute;
            r_s8.second_of_minute <= r_s7_t.second;
        end
    end

endmodule

FILE: hdl/unix_seconds_to_calendar_unit.sv
// Channel  Direction  Payload
// i_in     input      unix_seconds
// o_out    output     year_since_2000, month_of_year, day_of_month,
//                     hour_of_day, minute_of_hour, second_of_minute
//
// A beat passes through eight register stages on its way to the output register,
// and one beat is accepted every cycle unless every stage is full and the output is stalled.
// Reset clears only the valid bits of the stages.
// Each stage holds its beat while the next one is full and stalled, so empty
// stages keep filling while a result waits at the output.
module unix_seconds_to_calendar_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    usc_in_if.sink   i_in,
    usc_out_if.source o_out
);

    logic             mid_valid;
    logic             mid_ready;
    usc_pkg::t_split  mid_split;
    usc_pkg::t_result res;

    usc_time_split u_time_split (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .o_ready   (i_in.ready),
        .i_seconds (i_in.unix_seconds),
        .o_valid   (mid_valid),
        .i_ready   (mid_ready),
        .o_split   (mid_split)
    );

    usc_date_calc u_date_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (mid_valid),
        .o_ready  (mid_ready),
        .i_split  (mid_split),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (res)
    );

    assign o_out.year_since_2000 = res.year_since_2000;
    assign o_out.month_of_year = res.month_of_year;
    assign o_out.day_of_month = res.day_of_month;
    assign o_out.hour_of_day = res.hour_of_day;
    assign o_out.minute_of_hour = res.minute_of_hour;
    assign o_out.second_of_minute = res.second_of_minute;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("Output valid after reset.");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.month_of_year >= 4'd1) && (o_out.month_of_year <= 4'd12))
        else $error("Month out of range.");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.hour_of_day <= 5'd23) && (o_out.minute_of_hour <= 6'd59)
                        && (o_out.second_of_minute <= 6'd59) && (o_out.day_of_month >= 5'd1))
        else $error("Time of day out of range.");

    a_feb_days: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.month_of_year == 4'd2)) |-> (o_out.day_of_month <= 5'd29))
        else $error("February day out of range.");

endmodule

FILE: verif/tb_unix_seconds_to_calendar_unit.sv
`timescale 1ns / 1ps

module tb_unix_seconds_to_calendar_unit;

    localparam int unsigned SECS_PER_MIN   = 60;
    localparam int unsigned MINS_PER_HOUR  = 60;
    localparam int unsigned HOURS_PER_DAY  = 24;
    localparam int unsigned SECS_PER_DAY   = 86400;
    localparam int unsigned DAYS_IN_YEAR   = 365;
    localparam int unsigned DAYS_IN_CYCLE  = 1461;
    localparam int unsigned EPOCH_YEAR     = 1969;
    localparam int unsigned CENTURY_YEAR   = 2000;
    localparam int unsigned LAST_DAY_INDEX = 49710;
    localparam int unsigned DRAIN_CYCLES   = 24;
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned MAX_PRINTED    = 40;

    typedef struct {
        logic [31:0]      secs;
        usc_pkg::t_result date;
    } t_pending_date;

    logic        clk;
    logic        rst_n;
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned error_count;
    int unsigned cycle_count;

    t_pending_date pending_dates[$];

    usc_in_if  in_ch ();
    usc_out_if out_ch ();

    unix_seconds_to_calendar_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [4:0] month_length(input logic [3:0] mon, input logic leap);
        case (mon)
            4'd1: begin
                month_length = leap ? 5'd29 : 5'd28;
            end
            4'd3, 4'd5, 4'd8, 4'd10: begin
                month_length = 5'd30;
            end
            default: begin
                month_length = 5'd31;
            end
        endcase
    endfunction

    // Every year divisible by four is a leap year, 2100 included. Days are counted
    // from 1969-01-01 so that each four-year cycle ends with its leap year.
    function automatic usc_pkg::t_result calendar_of(input logic [31:0] secs);
        usc_pkg::t_result r;
        logic [31:0] mins;
        logic [31:0] hrs;
        logic [31:0] days;
        logic [31:0] cycle_idx;
        logic [31:0] rest;
        logic [31:0] year_in_cycle;
        logic [31:0] doy;
        logic [31:0] year_ofs;
        logic [31:0] hour_val;
        logic [31:0] minute_val;
        logic [31:0] second_val;
        logic [3:0]  mon;
        logic        leap;
        second_val = secs % SECS_PER_MIN;
        mins = secs / SECS_PER_MIN;
        minute_val = mins % MINS_PER_HOUR;
        hrs = mins / MINS_PER_HOUR;
        hour_val = hrs % HOURS_PER_DAY;
        days = hrs / HOURS_PER_DAY + DAYS_IN_YEAR;
        cycle_idx = days / DAYS_IN_CYCLE;
        rest = days % DAYS_IN_CYCLE;
        year_in_cycle = rest / DAYS_IN_YEAR;
        if (year_in_cycle > 32'd3) begin
            year_in_cycle = 32'd3;
        end
        doy = rest - year_in_cycle * DAYS_IN_YEAR;
        leap = (year_in_cycle == 32'd3);
        year_ofs = EPOCH_YEAR + 32'd4 * cycle_idx + year_in_cycle - CENTURY_YEAR;
        mon = 4'd0;
        while (mon < 4'd11 && doy >= month_length(mon, leap)) begin
            doy = doy - month_length(mon, leap);
            mon = mon + 4'd1;
        end
        r.year_since_2000  = year_ofs[7:0];
        r.month_of_year    = mon + 4'd1;
        r.day_of_month     = doy[4:0] + 5'd1;
        r.hour_of_day      = hour_val[4:0];
        r.minute_of_hour   = minute_val[5:0];
        r.second_of_minute = second_val[5:0];
        return r;
    endfunction

    // Seconds at a given zero-based day of a year plus a time of day; may fall
    // outside the 32-bit range, which the caller handles.
    function automatic longint stamp_of(input int year, input int yday, input int tod);
        longint days;
        days = longint'(year - 1970) * DAYS_IN_YEAR + (year - 1) / 4 - 492 + yday;
        return days * SECS_PER_DAY + tod;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    task automatic send_seconds(input logic [31:0] secs);
        t_pending_date entry;
        if ($urandom_range(99) < idle_pct) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.unix_seconds <= secs;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        entry.secs = secs;
        entry.date = calendar_of(secs);
        pending_dates.push_back(entry);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge clk);
    endtask

    task automatic test_field_extremes();
        logic [31:0] patterns[$];
        patterns = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                     32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h5555_5555, 32'hAAAA_AAAA};
        foreach (patterns[i]) begin
            send_seconds(patterns[i]);
        end
    endtask

    task automatic test_calendar_corners();
        longint corners[$];
        corners = '{stamp_of(1972, 59, 0),                 stamp_of(1972, 365, 0),
                    stamp_of(1972, 365, SECS_PER_DAY - 1), stamp_of(1973, 0, 0),
                    stamp_of(2000, 59, 45296),             stamp_of(2000, 365, 43200),
                    stamp_of(2100, 58, SECS_PER_DAY - 1),  stamp_of(2100, 59, 0),
                    stamp_of(2100, 60, 0),                 stamp_of(2104, 365, 3723),
                    stamp_of(2106, 0, 0)};
        foreach (corners[i]) begin
            send_seconds(corners[i][31:0]);
        end
    endtask

    // Most beats land near day, month and year boundaries or on random days;
    // the rest are raw 32-bit values so that every input bit toggles.
    task automatic test_random_dates(input int count, input int unsigned sender_idle,
                                     input int unsigned receiver_stall);
        longint stamp;
        int     year;
        int     yday;
        int     tod;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        repeat (count) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    stamp = $urandom();
                end
                4, 5, 6: begin
                    stamp = longint'($urandom_range(LAST_DAY_INDEX)) * SECS_PER_DAY
                            + $urandom_range(SECS_PER_DAY - 1);
                end
                default: begin
                    year = $urandom_range(1970, 2106);
                    case ($urandom_range(5))
                        0: yday = -1;
                        1: yday = 0;
                        2: yday = 58;
                        3: yday = 59;
                        4: yday = 60;
                        default: yday = 365;
                    endcase
                    case ($urandom_range(2))
                        0: tod = 0;
                        1: tod = SECS_PER_DAY - 1;
                        default: tod = $urandom_range(SECS_PER_DAY - 1);
                    endcase
                    stamp = stamp_of(year, yday, tod);
                end
            endcase
            if (stamp < 0 || stamp > 64'hFFFF_FFFF) begin
                stamp = $urandom();
            end
            send_seconds(stamp[31:0]);
        end
    endtask

    always @(negedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        t_pending_date want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_dates.size() == 0) begin
                report_mismatch("result beat with no date pending");
            end else begin
                want = pending_dates.pop_front();
                if (out_ch.year_since_2000 !== want.date.year_since_2000) begin
                    report_mismatch($sformatf("secs %0d year %0d, want %0d", want.secs,
                        out_ch.year_since_2000, want.date.year_since_2000));
                end
                if (out_ch.month_of_year !== want.date.month_of_year) begin
                    report_mismatch($sformatf("secs %0d month %0d, want %0d", want.secs,
                        out_ch.month_of_year, want.date.month_of_year));
                end
                if (out_ch.day_of_month !== want.date.day_of_month) begin
                    report_mismatch($sformatf("secs %0d day %0d, want %0d", want.secs,
                        out_ch.day_of_month, want.date.day_of_month));
                end
                if (out_ch.hour_of_day !== want.date.hour_of_day) begin
                    report_mismatch($sformatf("secs %0d hour %0d, want %0d", want.secs,
                        out_ch.hour_of_day, want.date.hour_of_day));
                end
                if (out_ch.minute_of_hour !== want.date.minute_of_hour) begin
                    report_mismatch($sformatf("secs %0d minute %0d, want %0d", want.secs,
                        out_ch.minute_of_hour, want.date.minute_of_hour));
                end
                if (out_ch.second_of_minute !== want.date.second_of_minute) begin
                    report_mismatch($sformatf("secs %0d second %0d, want %0d", want.secs,
                        out_ch.second_of_minute, want.date.second_of_minute));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("unix_seconds_to_calendar_unit regression: fail");
            $finish;
        end
    end

    initial begin
        error_count        = 0;
        idle_pct           = 0;
        stall_pct          = 0;
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.unix_seconds = 32'd0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_calendar_corners();
        wait_results_drained();
        test_random_dates(460, 0, 0);
        wait_results_drained();
        test_random_dates(460, 65, 0);
        wait_results_drained();
        test_random_dates(460, 0, 65);
        wait_results_drained();
        test_random_dates(460, 33, 33);
        wait_results_drained();
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("unix_seconds_to_calendar_unit regression: pass");
        end else begin
            $display("unix_seconds_to_calendar_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/usc_pkg.sv
hdl/usc_if.sv
hdl/usc_time_split.sv
hdl/usc_date_calc.sv
hdl/unix_seconds_to_calendar_unit.sv
verif/tb_unix_seconds_to_calendar_unit.sv
